### rtl/psg_note_and_decay_writer_macros.svh
// Assertion macros for the PSG note and decay writer.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PSG_NOTE_AND_DECAY_WRITER_MACROS_SVH
`define PSG_NOTE_AND_DECAY_WRITER_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset only
`define PNDW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define PNDW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PNDW_ASSERT(lbl, prop, msg)
`define PNDW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/pndw_pkg.sv
// Shared types, codes and constant tables for the PSG note and decay writer.
// No dependencies; every other source file apart from the macro header imports this package.
package pndw_pkg;

    localparam int PNDW_NUM_CHANNELS = 6;

    localparam int KIND_W     = 2;
    localparam int CHAN_W     = 4;
    localparam int NOTE_W     = 8;
    localparam int VEL_W      = 8;
    localparam int ADDR_W     = 5;
    localparam int VALUE_W    = 8;
    localparam int PERIOD_W   = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 3;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INIT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DECAY_ENABLE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VELOCITY_ENABLE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECAY_PERIOD    = 2'd2;

    localparam logic [PERIOD_W-1:0] DECAY_PERIOD_RST = 16'd125;

    // Steps of a play item, and the last step of an init item
    localparam logic [STEP_W-1:0] STEP_OCT       = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FREQ      = 3'd1;
    localparam logic [STEP_W-1:0] STEP_AMP       = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PLAY_LAST = STEP_AMP;
    localparam logic [STEP_W-1:0] STEP_INIT_LAST = 3'd6;

    localparam logic [NOTE_W-1:0]  NOTE_MAX      = 8'd127;
    localparam logic [NOTE_W-1:0]  NOTE_SILENT   = 8'd60;
    localparam logic [ADDR_W-1:0]  ADDR_OCT_BASE = 5'h10;
    localparam logic [ADDR_W-1:0]  ADDR_FRQ_BASE = 5'h08;
    localparam logic [VALUE_W-1:0] AMP_FULL      = 8'hFF;
    localparam logic [VALUE_W-1:0] LEVEL_FULL    = 8'd16;

    // Divide by 12 as (n * 43) >> 9, exact for n up to 128
    localparam int DIV12_MUL   = 43;
    localparam int DIV12_SHIFT = 9;
    localparam int PROD_W      = NOTE_W + 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_PLAY,
        ST_SCAN,
        ST_TICK
    } pndw_state_t;

    typedef enum logic [1:0] {
        SRC_INIT,
        SRC_PLAY,
        SRC_TICK
    } pndw_src_t;

    typedef struct packed {
        logic              capture;
        logic              clear;
        logic              scan;
        logic              emit;
        pndw_src_t         src;
        logic [STEP_W-1:0] step;
        logic              last;
    } pndw_cmd_t;

    typedef struct packed {
        logic in_init;
        logic in_play;
        logic in_tick;
        logic scan_none;
        logic mask_one;
        logic slot_free;
    } pndw_status_t;

    function automatic logic [VALUE_W-1:0] tone_value(input logic [3:0] idx);
        logic [VALUE_W-1:0] v;
        case (idx)
            4'd0:    v = 8'd5;
            4'd1:    v = 8'd32;
            4'd2:    v = 8'd60;
            4'd3:    v = 8'd85;
            4'd4:    v = 8'd110;
            4'd5:    v = 8'd132;
            4'd6:    v = 8'd153;
            4'd7:    v = 8'd173;
            4'd8:    v = 8'd192;
            4'd9:    v = 8'd210;
            4'd10:   v = 8'd227;
            4'd11:   v = 8'd243;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] init_addr(input logic [STEP_W-1:0] step);
        logic [ADDR_W-1:0] a;
        case (step)
            3'd0, 3'd1, 3'd2: a = 5'h1C;
            3'd3:             a = 5'h14;
            3'd4:             a = 5'h15;
            3'd5:             a = 5'h18;
            default:          a = 5'h19;
        endcase
        return a;
    endfunction

    function automatic logic [VALUE_W-1:0] init_value(input logic [STEP_W-1:0] step);
        logic [VALUE_W-1:0] v;
        case (step)
            3'd0:    v = 8'h02;
            3'd2:    v = 8'h01;
            3'd3:    v = 8'h3F;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### rtl/pndw_if.sv
// Valid/ready channel interfaces for note events in and register writes out.
// Depends on pndw_pkg for field widths.
interface pndw_in_if import pndw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;

    modport source (output valid, kind, channel, note, velocity, input ready);
    modport sink   (input valid, kind, channel, note, velocity, output ready);
endinterface

interface pndw_out_if import pndw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  reg_addr;
    logic [VALUE_W-1:0] reg_value;
    logic               last;

    modport source (output valid, reg_addr, reg_value, last, input ready);
    modport sink   (input valid, reg_addr, reg_value, last, output ready);
endinterface

### rtl/pndw_ctrl.sv
// Sequencing state machine: accepts items and steps through their register writes.
// Depends on pndw_pkg and the assertion macro header.
`include "psg_note_and_decay_writer_macros.svh"

module pndw_ctrl import pndw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  pndw_status_t status,
    output pndw_cmd_t    cmd
);

    pndw_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                step_next = '0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.in_init)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_INIT;
                    end
                    else if (status.in_play)
                        state_next = ST_PLAY;
                    else if (status.in_tick)
                        state_next = ST_SCAN;
                end
            end
            ST_INIT:
            begin
                cmd.src  = SRC_INIT;
                cmd.step = step_reg;
                cmd.last = (step_reg == STEP_INIT_LAST);
                if (status.slot_free)
                begin
                    cmd.emit  = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (cmd.last)
                        state_next = ST_IDLE;
                end
            end
            ST_PLAY:
            begin
                cmd.src  = SRC_PLAY;
                cmd.step = step_reg;
                cmd.last = (step_reg == STEP_PLAY_LAST);
                if (status.slot_free)
                begin
                    cmd.emit  = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (cmd.last)
                        state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = status.scan_none ? ST_IDLE : ST_TICK;
            end
            ST_TICK:
            begin
                cmd.src  = SRC_TICK;
                cmd.last = status.mask_one;
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (cmd.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PNDW_ASSERT_ALWAYS(a_no_emit_idle, !(cmd.emit && state_reg == ST_IDLE), "write issued while idle")
    `PNDW_ASSERT(a_init_step_range, (state_reg == ST_INIT) |-> (step_reg <= STEP_INIT_LAST), "init step overrun")
    `PNDW_ASSERT(a_scan_none_idle, (state_reg == ST_SCAN && status.scan_none) |=> (state_reg == ST_IDLE), "empty tick did not finish")

endmodule

### rtl/pndw_datapath.sv
// Datapath: configuration, per-channel octave and decay state, write formation
// and the output register. Depends on pndw_pkg and the assertion macro header.
`include "psg_note_and_decay_writer_macros.svh"

module pndw_datapath import pndw_pkg::*;
#(
    parameter int NUM_CHANNELS = PNDW_NUM_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pndw_cmd_t             cmd,
    output pndw_status_t          status,
    input  logic [KIND_W-1:0]     kind,
    input  logic [CHAN_W-1:0]     channel,
    input  logic [NOTE_W-1:0]     note,
    input  logic [VEL_W-1:0]      velocity,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_W-1:0]     reg_addr,
    output logic [VALUE_W-1:0]    reg_value,
    output logic                  last
);

    localparam int CH_W = $clog2(NUM_CHANNELS);

    // configuration
    logic                decay_enable_reg;
    logic                velocity_enable_reg;
    logic [PERIOD_W-1:0] decay_period_reg;

    // captured item
    logic [CHAN_W-1:0] ch_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;

    // per-channel state
    logic [7:0]            oct_kept_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] active_reg;
    logic [PERIOD_W-1:0]   count_reg [NUM_CHANNELS];
    logic [7:0]            level_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] mask_reg;

    // output register
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;

    logic [NOTE_W-1:0]  note_clamped;
    logic [PROD_W-1:0]  quot_prod;
    logic [3:0]         quot;
    logic [7:0]         oct;
    logic [3:0]         tone_idx;
    logic [CHAN_W-1:0]  partner_ch;
    logic               partner_ok;
    logic [7:0]         partner_oct;
    logic [7:0]         oct_value;
    logic [4:0]         amp_lvl;
    logic [VALUE_W-1:0] amp_value;
    logic [7:0]         level_start;
    logic [CH_W-1:0]    ch_idx;
    logic               play_update;

    logic [PERIOD_W-1:0]     cnt_inc [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] scan_hit;
    logic [CH_W-1:0]         pick_idx;
    logic [7:0]              tick_lvl;
    logic                    tick_emit;
    logic                    slot_free;

    logic [ADDR_W-1:0]  addr_next;
    logic [VALUE_W-1:0] value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_enable_reg    <= 1'b1;
            velocity_enable_reg <= 1'b1;
            decay_period_reg    <= DECAY_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DECAY_ENABLE:    decay_enable_reg    <= cfg_data[0];
                CFG_VELOCITY_ENABLE: velocity_enable_reg <= cfg_data[0];
                CFG_DECAY_PERIOD:    decay_period_reg    <= cfg_data[PERIOD_W-1:0];
                default:             ;
            endcase
        end
    end

    // out-of-range notes play note 60 silently; hold the note already plus one
    assign note_clamped = (note > NOTE_MAX) ? NOTE_SILENT : note;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= channel;
            note_reg <= note_clamped + 1'b1;
            vel_reg  <= (note > NOTE_MAX) ? '0 : velocity;
        end
    end

    assign quot_prod   = PROD_W'(note_reg) * PROD_W'(DIV12_MUL);
    assign quot        = quot_prod[DIV12_SHIFT +: 4];
    assign oct         = 8'(quot) - 8'd1;
    assign tone_idx    = 4'(note_reg - 8'(quot) * 8'd12);
    assign ch_idx      = ch_reg[CH_W-1:0];
    assign partner_ch  = ch_reg ^ 4'd1;
    assign partner_ok  = (partner_ch < CHAN_W'(NUM_CHANNELS));
    assign partner_oct = partner_ok ? oct_kept_reg[partner_ch[CH_W-1:0]] : 8'd0;
    assign oct_value   = ch_reg[0] ? ({oct[3:0], 4'b0} | partner_oct)
                                   : (oct | {partner_oct[3:0], 4'b0});
    assign amp_lvl     = vel_reg[7:3];
    assign amp_value   = velocity_enable_reg ? ({amp_lvl[3:0], 4'b0} | {3'b0, amp_lvl})
                                             : AMP_FULL;
    assign level_start = velocity_enable_reg ? {3'b0, amp_lvl} : LEVEL_FULL;
    assign play_update = cmd.emit && (cmd.src == SRC_PLAY) && (cmd.step == STEP_OCT);
    assign tick_emit   = cmd.emit && (cmd.src == SRC_TICK);

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            cnt_inc[i]  = count_reg[i] + 1'b1;
            scan_hit[i] = active_reg[i] && (cnt_inc[i] >= decay_period_reg);
        end
    end

    // lowest stepping channel goes first
    always_comb
    begin
        pick_idx = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                pick_idx = CH_W'(i);
        end
    end

    assign tick_lvl = level_reg[pick_idx] + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            mask_reg   <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                oct_kept_reg[i] <= '0;
                count_reg[i]    <= '0;
                level_reg[i]    <= '0;
            end
        end
        else if (cmd.clear)
        begin
            active_reg <= '0;
            mask_reg   <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                oct_kept_reg[i] <= '0;
                count_reg[i]    <= '0;
                level_reg[i]    <= '0;
            end
        end
        else
        begin
            if (play_update)
            begin
                oct_kept_reg[ch_idx] <= oct;
                if (decay_enable_reg)
                begin
                    active_reg[ch_idx] <= 1'b1;
                    count_reg[ch_idx]  <= '0;
                    level_reg[ch_idx]  <= level_start;
                end
            end
            if (cmd.scan)
            begin
                mask_reg <= scan_hit;
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (scan_hit[i])
                    begin
                        count_reg[i]  <= '0;
                        level_reg[i]  <= level_reg[i] - 8'd1;
                        active_reg[i] <= (level_reg[i] != 8'd0);
                    end
                    else if (active_reg[i])
                        count_reg[i] <= cnt_inc[i];
                end
            end
            else if (tick_emit)
                mask_reg[pick_idx] <= 1'b0;
        end
    end

    always_comb
    begin
        addr_next  = init_addr(cmd.step);
        value_next = init_value(cmd.step);
        case (cmd.src)
            SRC_PLAY:
            begin
                case (cmd.step)
                    STEP_OCT:
                    begin
                        addr_next  = ADDR_OCT_BASE + ADDR_W'(ch_reg >> 1);
                        value_next = oct_value;
                    end
                    STEP_FREQ:
                    begin
                        addr_next  = ADDR_FRQ_BASE + ADDR_W'(ch_reg);
                        value_next = tone_value(tone_idx);
                    end
                    default:
                    begin
                        addr_next  = ADDR_W'(ch_reg);
                        value_next = amp_value;
                    end
                endcase
            end
            SRC_TICK:
            begin
                addr_next  = ADDR_W'(pick_idx);
                value_next = {tick_lvl[3:0], 4'b0} | tick_lvl;
            end
            default:
            begin
                addr_next  = init_addr(cmd.step);
                value_next = init_value(cmd.step);
            end
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            addr_reg  <= addr_next;
            value_reg <= value_next;
            last_reg  <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign reg_addr  = addr_reg;
    assign reg_value = value_reg;
    assign last      = last_reg;

    assign status.in_init   = (kind == KIND_INIT);
    assign status.in_play   = (kind == KIND_PLAY) && (channel < CHAN_W'(NUM_CHANNELS));
    assign status.in_tick   = (kind == KIND_TICK) && decay_enable_reg;
    assign status.scan_none = (scan_hit == '0);
    assign status.mask_one  = ((mask_reg & (mask_reg - NUM_CHANNELS'(1))) == '0);
    assign status.slot_free = slot_free;

    `PNDW_ASSERT_ALWAYS(a_emit_slot_free, !cmd.emit || slot_free, "write issued over a held result")
    `PNDW_ASSERT(a_tick_mask_nonempty, tick_emit |-> (mask_reg != '0), "tick write with no stepping channel")
    `PNDW_ASSERT(a_tick_mask_drop, tick_emit |=> ($countones(mask_reg) + 1 == $countones($past(mask_reg))), "tick write did not retire one channel")

endmodule

### rtl/psg_note_and_decay_writer.sv
// Top level of the PSG note and decay writer: controller plus datapath.
// Depends on pndw_pkg, pndw_if, pndw_ctrl and pndw_datapath.
//
// Usage:
//   in_ch carries one event per transaction (tick, play, stop, init). out_ch
//   carries chip register writes; last marks the final write of an event.
//   The cfg port writes decay_enable (0), velocity_enable (1), decay_period
//   (2) on any edge with cfg_we high; write only while the block is idle.
//   Events are taken one at a time. An init event is accepted and then
//   issues its 7 writes, a play event its 3 writes, one per cycle while
//   out_ch does not stall. A stop event, an ignored channel or a tick
//   with decay off issues no write; any other tick first scans the
//   channels, then issues one write per stepping channel. The first
//   write of an event is registered in the single output register once
//   the controller has left idle, and for a tick once the scan is done;
//   the controller issues at most one write per cycle.
//   A stall on out_ch holds the current write and pauses the sequence; the
//   next event is still taken while the final write waits to be accepted.
//   Reset clears all channel state and loads the configuration defaults
//   (decay on, velocity on, period 125); no writes are issued at reset.
module psg_note_and_decay_writer import pndw_pkg::*;
#(
    parameter int NUM_CHANNELS = PNDW_NUM_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pndw_in_if.sink               in_ch,
    pndw_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pndw_cmd_t    cmd;
    pndw_status_t status;

    pndw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pndw_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (in_ch.kind),
        .channel   (in_ch.channel),
        .note      (in_ch.note),
        .velocity  (in_ch.velocity),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .reg_addr  (out_ch.reg_addr),
        .reg_value (out_ch.reg_value),
        .last      (out_ch.last)
    );

endmodule

### bench/psg_note_and_decay_writer_tb.sv
`timescale 1ns / 100ps
// Testbench for psg_note_and_decay_writer: feeds note events and checks every chip write
// against a channel-level model of the octave, tone, amplitude and decay behaviour.
// Depends on pndw_pkg and the pndw_in_if / pndw_out_if channel interfaces.
module psg_note_and_decay_writer_tb;
    import pndw_pkg::*;

    localparam int CHANNELS = 6;
    localparam logic [ADDR_W-1:0] OCT_REG_BASE  = 5'h10;
    localparam logic [ADDR_W-1:0] TONE_REG_BASE = 5'h08;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_TRIGGER  = 70;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } note_event_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic               last;
    } chip_write_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    pndw_in_if  in_if ();
    pndw_out_if out_if ();

    psg_note_and_decay_writer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_if),
        .out_ch   (out_if),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    logic [VALUE_W-1:0] tone_code [12] = '{8'd5, 8'd32, 8'd60, 8'd85, 8'd110, 8'd132,
                                           8'd153, 8'd173, 8'd192, 8'd210, 8'd227, 8'd243};
    logic [ADDR_W-1:0]  startup_addr  [7] = '{5'h1C, 5'h1C, 5'h1C, 5'h14, 5'h15, 5'h18, 5'h19};
    logic [VALUE_W-1:0] startup_value [7] = '{8'h02, 8'h00, 8'h01, 8'h3F, 8'h00, 8'h00, 8'h00};

    // Channel model
    logic                decay_on;
    logic                velocity_on;
    logic [PERIOD_W-1:0] step_period;
    logic [7:0]          octave_of   [CHANNELS];
    logic                decaying    [CHANNELS];
    logic [15:0]         ticks_since [CHANNELS];
    logic [7:0]          level_of    [CHANNELS];

    note_event_t pending_events [$];
    chip_write_t expected_writes [$];
    note_event_t driven_event;
    chip_write_t want;

    int fail_count      = 0;
    int events_accepted = 0;
    int idle_pct        = 0;
    int send_gap        = 0;
    int stall_left      = 0;
    int hold_left       = 0;
    bit held_off        = 1'b0;

    function automatic logic [VALUE_W-1:0] amp_byte(input logic [7:0] lvl);
        return {lvl[3:0], 4'b0000} | lvl;
    endfunction

    function automatic void clear_channels();
        for (int c = 0; c < CHANNELS; c++)
        begin
            octave_of[c]   = '0;
            decaying[c]    = 1'b0;
            ticks_since[c] = '0;
            level_of[c]    = '0;
        end
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic void predict_chip_writes(input note_event_t ev);
        chip_write_t batch [$];
        logic [7:0]  nt;
        logic [7:0]  vel;
        logic [7:0]  n1;
        logic [7:0]  oct;
        logic [7:0]  partner;
        logic [7:0]  ov;
        logic [7:0]  lvl;
        int          ch;
        case (ev.kind)
            KIND_INIT:
            begin
                clear_channels();
                for (int i = 0; i < 7; i++)
                    batch.push_back(chip_write_t'{startup_addr[i], startup_value[i], 1'b0});
            end
            KIND_PLAY:
            begin
                if (ev.channel < CHANNELS)
                begin
                    ch  = int'(ev.channel);
                    nt  = ev.note;
                    vel = ev.velocity;
                    // out-of-range notes play middle C silently
                    if (nt > 8'd127)
                    begin
                        nt  = 8'd60;
                        vel = 8'd0;
                    end
                    n1  = nt + 8'd1;
                    oct = n1 / 8'd12 - 8'd1;
                    octave_of[ch] = oct;
                    partner = octave_of[ch ^ 1];
                    if (ch % 2 == 0)
                        ov = oct | (partner << 4);
                    else
                        ov = (oct << 4) | partner;
                    batch.push_back(chip_write_t'{ADDR_W'(OCT_REG_BASE + ch / 2), ov, 1'b0});
                    batch.push_back(chip_write_t'{ADDR_W'(TONE_REG_BASE + ch),
                                                  tone_code[n1 % 12], 1'b0});
                    if (velocity_on)
                    begin
                        lvl = vel >> 3;
                        batch.push_back(chip_write_t'{ADDR_W'(ch), amp_byte(lvl), 1'b0});
                    end
                    else
                    begin
                        lvl = 8'd16;
                        batch.push_back(chip_write_t'{ADDR_W'(ch), 8'hFF, 1'b0});
                    end
                    if (decay_on)
                    begin
                        decaying[ch]    = 1'b1;
                        ticks_since[ch] = '0;
                        level_of[ch]    = lvl;
                    end
                end
            end
            KIND_TICK:
            begin
                if (decay_on)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (decaying[c])
                        begin
                            ticks_since[c] = ticks_since[c] + 16'd1;
                            if (ticks_since[c] >= step_period)
                            begin
                                batch.push_back(chip_write_t'{ADDR_W'(c), amp_byte(level_of[c]),
                                                              1'b0});
                                // stop once level zero has gone out
                                if (level_of[c] == 8'd0)
                                    decaying[c] = 1'b0;
                                level_of[c]    = level_of[c] - 8'd1;
                                ticks_since[c] = '0;
                            end
                        end
                    end
                end
            end
            KIND_STOP: ;
            default: ;
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_writes.push_back(batch[i]);
    endfunction

    function automatic note_event_t random_event();
        note_event_t ev;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 45)
            ev.kind = KIND_TICK;
        else if (r < 88)
            ev.kind = KIND_PLAY;
        else if (r < 94)
            ev.kind = KIND_STOP;
        else
            ev.kind = KIND_INIT;
        ev.channel  = ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom_range(6, 15))
                                                  : CHAN_W'($urandom_range(0, 5));
        ev.note     = ($urandom_range(0, 99) < 85) ? NOTE_W'($urandom_range(0, 127))
                                                   : NOTE_W'($urandom_range(0, 255));
        ev.velocity = VEL_W'($urandom_range(0, 255));
        return ev;
    endfunction

    task automatic queue_event(input logic [KIND_W-1:0] kind, input int ch, input int nt,
                               input int vel);
        pending_events.push_back(note_event_t'{kind, CHAN_W'(ch), NOTE_W'(nt), VEL_W'(vel)});
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= CFG_DATA_W'(data);
        case (idx)
            CFG_DECAY_ENABLE:    decay_on    = data[0];
            CFG_VELOCITY_ENABLE: velocity_on = data[0];
            CFG_DECAY_PERIOD:    step_period = PERIOD_W'(data);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int decay, input int velocity, input int period);
        write_reg(CFG_DECAY_ENABLE, decay);
        write_reg(CFG_VELOCITY_ENABLE, velocity);
        write_reg(CFG_DECAY_PERIOD, period);
    endtask

    // Hold until every queued event is taken and every predicted write has come out
    task automatic wait_idle();
        int waited;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while ((pending_events.size() > 0 || in_if.valid || expected_writes.size() > 0)
               && waited < 200000);
        if (expected_writes.size() > 0)
        begin
            $error("%0d expected writes never arrived", expected_writes.size());
            fail_count++;
            expected_writes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        @(negedge clk);
        repeat (count) pending_events.push_back(random_event());
        wait_idle();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Event driver: one transaction per handshake, random gaps between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
            begin
                predict_chip_writes(driven_event);
                events_accepted++;
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end
                else if (pending_events.size() > 0)
                begin
                    driven_event = pending_events.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.kind     <= driven_event.kind;
                    in_if.channel  <= driven_event.channel;
                    in_if.note     <= driven_event.note;
                    in_if.velocity <= driven_event.velocity;
                    send_gap = pick_gap(idle_pct);
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Write monitor and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_writes.size() == 0)
            begin
                $error("unexpected write: reg_addr %h reg_value %h last %b",
                       out_if.reg_addr, out_if.reg_value, out_if.last);
                fail_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (out_if.reg_addr !== want.addr)
                begin
                    $error("reg_addr: expected %h, got %h", want.addr, out_if.reg_addr);
                    fail_count++;
                end
                if (out_if.reg_value !== want.value)
                begin
                    $error("reg_value: expected %h, got %h", want.value, out_if.reg_value);
                    fail_count++;
                end
                if (out_if.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, out_if.last);
                    fail_count++;
                end
            end
        end
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_if.ready <= 1'b0;
        end
        else if (!held_off && events_accepted >= HOLD_TRIGGER)
        begin
            // long hold-off so the block backs up and stalls its input
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_if.ready <= 1'b0;
        end
        else
        begin
            out_if.ready <= 1'b1;
            stall_left = pick_gap(idle_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_data       = '0;
        in_if.valid    = 1'b0;
        in_if.kind     = '0;
        in_if.channel  = '0;
        in_if.note     = '0;
        in_if.velocity = '0;
        out_if.ready   = 1'b0;
        decay_on       = 1'b1;
        velocity_on    = 1'b1;
        step_period    = DECAY_PERIOD_RST;
        clear_channels();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: init, default settings, field extremes, ignored channels, stop and tick
        idle_pct = 25;
        @(negedge clk);
        queue_event(KIND_INIT, 0, 0, 0);
        queue_event(KIND_PLAY, 0, 0, 0);
        queue_event(KIND_PLAY, 1, 127, 255);
        queue_event(KIND_PLAY, 2, 128, 200);
        queue_event(KIND_PLAY, 3, 255, 8);
        queue_event(KIND_PLAY, 4, 10, 127);
        queue_event(KIND_PLAY, 5, 11, 128);
        queue_event(KIND_PLAY, 6, 60, 100);
        queue_event(KIND_PLAY, 15, 255, 255);
        queue_event(KIND_STOP, 0, 60, 64);
        queue_event(KIND_STOP, 15, 255, 255);
        queue_event(KIND_TICK, 0, 0, 0);
        queue_event(KIND_TICK, 15, 255, 255);
        wait_idle();

        // Directed: full amplitude, a decay step on every tick and an init mid-run
        set_config(1, 0, 0);
        @(negedge clk);
        queue_event(KIND_PLAY, 0, 60, 0);
        queue_event(KIND_PLAY, 1, 72, 255);
        queue_event(KIND_TICK, 0, 0, 0);
        queue_event(KIND_TICK, 0, 0, 0);
        queue_event(KIND_PLAY, 2, 200, 17);
        queue_event(KIND_TICK, 0, 0, 0);
        queue_event(KIND_INIT, 0, 0, 0);
        queue_event(KIND_TICK, 0, 0, 0);
        queue_event(KIND_PLAY, 5, 127, 7);
        queue_event(KIND_TICK, 0, 0, 0);
        wait_idle();

        set_config(1, 1, 2);
        idle_pct = 30;
        run_random(100);

        set_config(1, 0, 1);
        idle_pct = 50;
        run_random(30);

        set_config(0, 1, 3);
        idle_pct = 0;
        run_random(20);

        set_config(1, 1, 65535);
        idle_pct = 25;
        run_random(15);

        set_config(1, 1, 0);
        idle_pct = 0;
        run_random(30);

        set_config(1, 0, 5);
        idle_pct = 40;
        run_random(20);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/pndw_pkg.sv
rtl/pndw_if.sv
rtl/pndw_ctrl.sv
rtl/pndw_datapath.sv
rtl/psg_note_and_decay_writer.sv
bench/psg_note_and_decay_writer_tb.sv
